>>> hdl/sts_pkg.sv
// Shared types and constants for the sorted tag set.
// Used by sts_cell and sorted_tag_set_core; depends on nothing else.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 32;
    localparam int OP_W         = 2;
    localparam int TAG_W        = 32;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_ERASE    = 2'd1,
        OP_CONTAINS = 2'd2
    } op_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } sts_ctl_t;

endpackage

>>> hdl/sorted_tag_set_core.sv
// Top level of the sorted tag set: command capture, the cell chain and result register.
// Depends on sts_pkg and sts_cell.
`timescale 1ns / 1ps

// The block keeps up to CAPACITY distinct tags in ascending order in a chain
// of cells. An item is taken when start is high and busy is low; busy then
// stays high for one cycle while every cell compares its tag with the key in
// parallel and the chain shifts one place up (insert) or down (erase) in a
// single step. The result is registered at the edge that ends that busy cycle
// and appears on the result ports with done high for one cycle, and must be
// captured at the edge that ends that cycle because it is not held. No new
// item is taken while the registered command stage in front of the chain
// compare holds one. Operation code 3 behaves as a membership test.
module sorted_tag_set_core
    import sts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        operation,
    input  logic [TAG_W-1:0]       tag,
    output logic                   done,
    output logic                   was_present,
    output logic                   full_drop,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Command stage: holds the item while the chain works on it.
    logic                cmd_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [TAG_BITS-1:0] key_reg;
    logic [TAG_BITS-1:0] key_next;
    logic [TAG_BITS+TAG_W-1:0] tag_ext;

    // Chain signals, one entry per cell.
    logic [TAG_BITS-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    sts_ctl_t            ctl;

    logic                is_insert;
    logic                is_erase;
    logic                present;
    logic                full;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    logic                done_reg;
    logic                was_present_reg;
    logic                full_drop_reg;

    // Only the low TAG_BITS bits of the tag take part in the ordering.
    assign tag_ext  = {{TAG_BITS{1'b0}}, tag};
    assign key_next = tag_ext[TAG_BITS-1:0];

    assign busy = cmd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !cmd_valid_reg)
        begin
            op_reg  <= operation;
            key_reg <= key_next;
        end
    end

    // Decode: the sorted order makes lt a prefix, and at most one cell
    // matches, so a plain OR over the match flags gives membership.
    assign is_insert = (op_reg == OP_INSERT);
    assign is_erase  = (op_reg == OP_ERASE);
    assign present   = |cell_eq;
    assign full      = cell_valid[CAPACITY-1];

    assign ctl.shift_up   = cmd_valid_reg && is_insert && !present && !full;
    assign ctl.shift_down = cmd_valid_reg && is_erase && present;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [TAG_BITS-1:0] l_entry;
            logic                l_valid;
            logic                l_lt;
            logic [TAG_BITS-1:0] r_entry;
            logic                r_valid;

            // The first cell sees a virtual left neighbor that is valid and
            // below the key; the last cell sees an empty right neighbor.
            if (i == 0)
            begin : g_first
                assign l_entry = key_reg;
                assign l_valid = 1'b1;
                assign l_lt    = 1'b1;
            end
            else
            begin : g_inner_l
                assign l_entry = cell_entry[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_lt    = cell_lt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign r_entry = key_reg;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner_r
                assign r_entry = cell_entry[i+1];
                assign r_valid = cell_valid[i+1];
            end

            sts_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .key         (key_reg),
                .left_entry  (l_entry),
                .left_valid  (l_valid),
                .left_lt     (l_lt),
                .right_entry (r_entry),
                .right_valid (r_valid),
                .entry       (cell_entry[i]),
                .valid       (cell_valid[i]),
                .lt          (cell_lt[i]),
                .eq          (cell_eq[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.shift_up)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.shift_down)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            was_present_reg <= present;
            full_drop_reg   <= is_insert && !present && full;
        end
    end

    // The reported count wraps at 128, as the field is seven bits wide.
    assign count_ext   = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign done        = done_reg;
    assign was_present = was_present_reg;
    assign full_drop   = full_drop_reg;
    assign entry_count = count_ext[COUNT_OUT_W-1:0];

`ifndef SYNTHESIS
    // The count register always agrees with the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("count does not match occupied cells");

    // Occupied cells form a contiguous run starting at the first cell.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + CAPACITY'(1))) == '0))
        else $error("occupied cells are not a prefix of the chain");

    // A result strobe follows a busy cycle and never two in a row.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a command in flight");

    // A dropped insert only happens on a full set that stays full.
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && full_drop) |-> (int'(count_reg) == CAPACITY && !was_present))
        else $error("insert dropped while the set was not full");
`endif

endmodule

>>> hdl/sts_cell.sv
// One storage cell of the sorted tag chain: holds one tag and its valid bit.
// Depends on sts_pkg for the shift command struct.
`timescale 1ns / 1ps

module sts_cell
    import sts_pkg::*;
#(
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sts_ctl_t            ctl,
    input  logic [TAG_BITS-1:0] key,
    input  logic [TAG_BITS-1:0] left_entry,
    input  logic                left_valid,
    input  logic                left_lt,
    input  logic [TAG_BITS-1:0] right_entry,
    input  logic                right_valid,
    output logic [TAG_BITS-1:0] entry,
    output logic                valid,
    output logic                lt,
    output logic                eq
);

    logic [TAG_BITS-1:0] entry_reg;
    logic [TAG_BITS-1:0] entry_next;
    logic                valid_reg;
    logic                valid_next;

    assign lt    = valid_reg && (entry_reg < key);
    assign eq    = valid_reg && (entry_reg == key);
    assign entry = entry_reg;
    assign valid = valid_reg;

    // Cells at or above the key position move; cells below it keep their tag.
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.shift_up && !lt)
        begin
            entry_next = left_lt ? key : left_entry;
            valid_next = left_valid;
        end
        else if (ctl.shift_down && !lt)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> tb/tb_top.sv
// Self-checking bench for sorted_tag_set_core: a directed table, then about 1400 random items.
// Depends on sts_pkg and the sorted_tag_set_core RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import sts_pkg::*;

    // Operation code 3 has no name in the package; the block treats it as a
    // membership test, so the bench keeps a name of its own for it.
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int POOL_SIZE     = 96;
    localparam int IDLE_PERCENT  = 23;
    localparam int QUIET_FIRST   = 500;
    localparam int QUIET_LAST    = 849;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;

    // One result of the block, as the bench expects or observes it.
    typedef struct packed {
        logic                   was_present;
        logic                   full_drop;
        logic [COUNT_OUT_W-1:0] entry_count;
    } set_result_t;

    // One row of the directed table. A row with reps above one issues that
    // many inserts or erases with the tag stepping up by one each time.
    // Where has_typed is set, the expected result is written into the row
    // and the predictor only keeps its state in step.
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;
        int               reps;
        bit               has_typed;
        set_result_t      typed;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OP_W-1:0]        operation;
    logic [TAG_W-1:0]       tag;
    logic                   done;
    logic                   was_present;
    logic                   full_drop;
    logic [COUNT_OUT_W-1:0] entry_count;

    // The tags the set holds, kept in ascending order, and the results
    // still owed by the block, oldest first.
    logic [TAG_W-1:0] held_tags [$];
    set_result_t      awaited_results [$];
    stim_row_t        directed_rows [$];
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];

    int  mismatches = 0;
    bit  idle_enable = 1'b1;

    sorted_tag_set_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .tag         (tag),
        .done        (done),
        .was_present (was_present),
        .full_drop   (full_drop),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    // Applies one operation to the bench's copy of the set and returns the
    // result the block must give for it. The position found is the first
    // slot whose tag is not below the key, so presence is a single compare.
    function automatic set_result_t apply_set_op(logic [OP_W-1:0] op, logic [TAG_W-1:0] key);
        set_result_t res;
        int          pos;
        bit          present;
        pos = 0;
        while (pos < held_tags.size() && held_tags[pos] < key)
            pos++;
        present = (pos < held_tags.size()) && (held_tags[pos] == key);
        res.was_present = present;
        res.full_drop   = 1'b0;
        if (op == OP_INSERT && !present)
        begin
            // An absent tag offered to a full set is dropped and flagged.
            if (held_tags.size() >= CAPACITY_DEF)
                res.full_drop = 1'b1;
            else
                held_tags.insert(pos, key);
        end
        else if (op == OP_ERASE && present)
        begin
            held_tags.delete(pos);
        end
        // Contains and the undefined code leave the set as it is.
        res.entry_count = COUNT_OUT_W'(held_tags.size());
        return res;
    endfunction

    // Presents one item and returns once the block has taken it. The caller
    // enters right after a rising edge, so start is changed at most once per
    // edge: either lowered for a gap and raised later, or left high with the
    // next item's fields.
    task automatic issue_item(logic [OP_W-1:0] op, logic [TAG_W-1:0] key,
                              bit has_typed, set_result_t typed);
        set_result_t predicted;
        int          gap;
        if (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        tag       <= key;
        // The item is taken at the first edge where busy is seen low.
        do
            @(posedge clk);
        while (busy);
        predicted = apply_set_op(op, key);
        awaited_results.push_back(has_typed ? typed : predicted);
    endtask

    function automatic void add_row(logic [OP_W-1:0] op, logic [TAG_W-1:0] key, int reps,
                                    bit has_typed, logic wp, logic fd, int cnt);
        stim_row_t row;
        row.op                = op;
        row.tag               = key;
        row.reps              = reps;
        row.has_typed         = has_typed;
        row.typed.was_present = wp;
        row.typed.full_drop   = fd;
        row.typed.entry_count = COUNT_OUT_W'(cnt);
        directed_rows.push_back(row);
    endfunction

    // Picks a tag for a random item. Most picks come from a fixed pool or
    // from the set itself so that inserts and erases often hit; neighbors of
    // held tags probe the ordering compare, and fully random tags make every
    // bit of the field toggle.
    function automatic logic [TAG_W-1:0] pick_tag();
        int               sel;
        logic [TAG_W-1:0] member;
        sel = $urandom_range(0, 99);
        if (held_tags.size() != 0 && sel >= 45 && sel < 85)
        begin
            member = held_tags[$urandom_range(0, held_tags.size() - 1)];
            if (sel < 75)
                return member;
            return $urandom_range(0, 1) ? member + 1'b1 : member - 1'b1;
        end
        if (sel >= 85)
            return $urandom;
        return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Each result is on the ports for one cycle only and is taken at the
    // edge that ends that cycle; there is no way to hold it off.
    always @(posedge clk)
    begin
        set_result_t seen;
        set_result_t want;
        if (rst_n && done)
        begin
            seen.was_present = was_present;
            seen.full_drop   = full_drop;
            seen.entry_count = entry_count;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing outstanding: present=%b drop=%b count=%0d",
                             $realtime, was_present, full_drop, entry_count);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (seen.was_present !== want.was_present || seen.full_drop !== want.full_drop
                    || seen.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: present/drop/count expected %b/%b/%0d, got %b/%b/%0d",
                                 $realtime, want.was_present, want.full_drop, want.entry_count,
                                 was_present, full_drop, entry_count);
                end
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0] op;
        bit              filling;
        int              sel;
        int              waited;
        set_result_t     none;

        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_INSERT;
        tag       = '0;
        none      = '0;

        tag_pool[0] = 32'h0000_0000;
        tag_pool[1] = 32'hFFFF_FFFF;
        tag_pool[2] = 32'h8000_0000;
        tag_pool[3] = 32'h7FFF_FFFF;
        for (int k = 4; k < POOL_SIZE; k++)
            tag_pool[k] = $urandom;

        // Directed table. Typed rows are the ones whose result is plain from
        // the state: empty set, the extreme tags, duplicates, the undefined
        // code and a full set. The fill row brings the set to capacity.
        add_row(OP_CONTAINS,  32'h0000_0000,  1, 1, 0, 0, 0);
        add_row(OP_ERASE,     32'h0000_0005,  1, 1, 0, 0, 0);
        add_row(OP_INSERT,    32'h0000_0000,  1, 1, 0, 0, 1);
        add_row(OP_INSERT,    32'hFFFF_FFFF,  1, 1, 0, 0, 2);
        add_row(OP_INSERT,    32'h0000_0000,  1, 1, 1, 0, 2);
        add_row(OP_CONTAINS,  32'hFFFF_FFFF,  1, 1, 1, 0, 2);
        add_row(OP_UNDEFINED, 32'h0000_0000,  1, 1, 1, 0, 2);
        add_row(OP_UNDEFINED, 32'h0000_0007,  1, 1, 0, 0, 2);
        add_row(OP_INSERT,    32'h8000_0000,  1, 1, 0, 0, 3);
        add_row(OP_INSERT,    32'h7FFF_FFFF,  1, 0, 0, 0, 0);
        add_row(OP_INSERT,    32'h5555_5555,  1, 0, 0, 0, 0);
        add_row(OP_INSERT,    32'hAAAA_AAAA,  1, 0, 0, 0, 0);
        add_row(OP_ERASE,     32'h0000_0000,  1, 1, 1, 0, 5);
        add_row(OP_ERASE,     32'h0000_0000,  1, 1, 0, 0, 5);
        add_row(OP_CONTAINS,  32'h8000_0000,  1, 0, 0, 0, 0);
        add_row(OP_ERASE,     32'hFFFF_FFFF,  1, 1, 1, 0, 4);
        add_row(OP_ERASE,     32'h5555_5555,  1, 0, 0, 0, 0);
        add_row(OP_INSERT,    32'h0000_0001, 61, 0, 0, 0, 0);
        add_row(OP_INSERT,    32'h0000_1000,  1, 1, 0, 1, 64);
        add_row(OP_INSERT,    32'hFFFF_FFFF,  1, 1, 0, 1, 64);
        add_row(OP_INSERT,    32'h8000_0000,  1, 1, 1, 0, 64);
        add_row(OP_UNDEFINED, 32'h0000_0000,  1, 1, 0, 0, 64);
        add_row(OP_ERASE,     32'hAAAA_AAAA,  1, 1, 1, 0, 63);
        add_row(OP_INSERT,    32'h0000_0000,  1, 1, 0, 0, 64);
        add_row(OP_ERASE,     32'h0000_0000,  1, 1, 1, 0, 63);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
                issue_item(directed_rows[r].op, directed_rows[r].tag + k,
                           directed_rows[r].has_typed, directed_rows[r].typed);
        end

        // Random part. The set swings between filling and draining so that
        // it keeps passing through empty and full; a middle stretch runs
        // with start held high back to back.
        filling = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_enable = !(i >= QUIET_FIRST && i <= QUIET_LAST);
            if (held_tags.size() == 0)
                filling = 1'b1;
            else if (held_tags.size() >= CAPACITY_DEF && $urandom_range(0, 99) < 30)
                filling = 1'b0;
            else if ($urandom_range(0, 99) < 2)
                filling = !filling;

            sel = $urandom_range(0, 99);
            if (sel < (filling ? 65 : 20))
                op = OP_INSERT;
            else if (sel < 80)
                op = OP_ERASE;
            else if (sel < 95)
                op = OP_CONTAINS;
            else
                op = OP_UNDEFINED;
            issue_item(op, pick_tag(), 1'b0, none);
        end
        start <= 1'b0;

        // Let the last results come out, then a few more cycles so that a
        // stray extra result would still be caught.
        waited = 0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0d results never arrived", awaited_results.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(3_000_000);
        $display("Timeout waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sts_pkg.sv
hdl/sts_cell.sv
hdl/sorted_tag_set_core.sv
tb/tb_top.sv
